// File: src/lics_pkg.sv
// Shared types, constants and elaboration-time functions of the inverse-CDF sampler.
package lics_pkg;

	localparam int IDX_W  = 7;
	localparam int CDF_W  = 33;
	localparam int LC_W   = 24;
	localparam int LF_W   = 18;
	localparam int X_W    = 32;
	localparam int FREQ_W = 54;
	localparam int BIN_W  = 7;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Hz per unit of 13.6 eV, fits in 52 bits.
	localparam logic [63:0] HZ_PER_UNIT = 64'd3288465385000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

	typedef struct packed {
		logic                   kind;
		logic [IDX_W-1:0]       entry_index;
		logic [CDF_W-1:0]       cdf_value;
		logic signed [LC_W-1:0] log_cdf_value;
		logic [LF_W-1:0]        log_freq_value;
		logic [X_W-1:0]         uniform_value;
	} in_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency_hz;
		logic [BIN_W-1:0]  bin_index;
	} out_item_t;

	// Classified request as handed from the front to the back.
	typedef struct packed {
		logic                   is_sample;
		logic                   wr_en;
		logic [IDX_W-1:0]       entry_index;
		logic [CDF_W-1:0]       cdf_value;
		logic signed [LC_W-1:0] log_cdf_value;
		logic [LF_W-1:0]        log_freq_value;
		logic [X_W-1:0]         x;
	} cmd_t;

	typedef logic [15:0][31:0] roots_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v    = v_in;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Entry k holds 2^(2^-(k+1)) in Q1.31, each root taken from the previous one.
	function automatic roots_t exp2_roots();
		roots_t      r;
		logic [63:0] root;
		root = isqrt64(64'd1 << 63);
		r[0] = root[31:0];
		for (int k = 1; k < 16; k++) begin
			root = isqrt64(root << 31);
			r[k] = root[31:0];
		end
		return r;
	endfunction

	localparam roots_t EXP2_ROOTS = exp2_roots();

endpackage

// File: src/lics_front.sv
// Front end: input queue that accepts and classifies load and sample requests.
module lics_front #(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lics_pkg::in_item_t  item,
	output logic                cmd_valid,
	output lics_pkg::cmd_t      cmd,
	input  logic                cmd_ready
);
	import lics_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int AW = ((IW > IDX_W) ? IW : IDX_W) + 1;

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		new_cmd.is_sample      = (item.kind == KIND_SAMPLE);
		// Loads aimed beyond the table lose their write enable here.
		new_cmd.wr_en          = (item.kind == KIND_LOAD) &&
			(AW'(item.entry_index) < AW'(TABLE_ENTRIES));
		new_cmd.entry_index    = item.entry_index;
		new_cmd.cdf_value      = item.cdf_value;
		new_cmd.log_cdf_value  = item.log_cdf_value;
		new_cmd.log_freq_value = item.log_freq_value;
		new_cmd.x              = (item.uniform_value == '0) ? X_W'(1) : item.uniform_value;
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= new_cmd;
	end

endmodule

// File: src/lics_log2.sv
// Iterative log2 unit: leading-one normalisation then sixteen squaring steps.
module lics_log2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lics_pkg::X_W-1:0]      x,
	output logic                          busy,
	output logic signed [lics_pkg::LC_W-1:0] lg
);
	import lics_pkg::*;

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lstate_t;

	lstate_t     state_q;
	logic [3:0]  cnt_q;
	logic [31:0] m_q;
	logic [4:0]  p_q;
	logic [15:0] frac_q;
	logic [63:0] sq;
	logic [32:0] t;

	assign sq   = 64'(m_q) * 64'(m_q);
	assign t    = sq[63:31];
	assign busy = (state_q != L_IDLE);
	// The integer part p-32 is always negative, so its six-bit code is {1, p}.
	assign lg   = LC_W'(signed'({1'b1, p_q, frac_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start)
						state_q <= L_NORM;
				end
				L_NORM: begin
					if (m_q[31]) begin
						cnt_q   <= 4'd0;
						state_q <= L_SQR;
					end
				end
				L_SQR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					m_q <= x;
					p_q <= 5'd31;
				end
			end
			L_NORM: begin
				if (!m_q[31]) begin
					m_q <= m_q << 1;
					p_q <= p_q - 5'd1;
				end
				frac_q <= '0;
			end
			L_SQR: begin
				frac_q <= {frac_q[14:0], t[32]};
				m_q    <= t[32] ? t[32:1] : t[31:0];
			end
			default: ;
		endcase
	end

endmodule

// File: src/lics_div.sv
// Bit-serial restoring divider, signed operands, quotient truncated toward zero.
module lics_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [(lics_pkg::LC_W+lics_pkg::LF_W+2)-1:0] num,
	input  logic signed [lics_pkg::LC_W:0] den,
	output logic                           busy,
	output logic signed [(lics_pkg::LC_W+lics_pkg::LF_W+2)-1:0] quo
);
	import lics_pkg::*;

	localparam int NUM_W = LC_W + LF_W + 2;
	localparam int DEN_W = LC_W + 1;
	localparam int CW    = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] d_q;
	logic             neg_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, n_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, d_q});
	assign busy  = busy_q;
	assign quo   = neg_q ? -signed'(n_q) : signed'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			d_q   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			rem_q <= '0;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, d_q}) : trial[DEN_W-1:0];
			n_q   <= {n_q[NUM_W-2:0], ge};
		end
	end

endmodule

// File: src/lics_back.sv
// Back end: tables, bin search, log-domain interpolation, exp2 scaling and result register.
module lics_back #(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  lics_pkg::cmd_t      cmd,
	output logic                cmd_ready,
	input  logic                pop,
	output logic                empty,
	output lics_pkg::out_item_t result
);
	import lics_pkg::*;

	localparam int IW     = $clog2(TABLE_ENTRIES);
	localparam int DIFF_W = LC_W + 1;
	localparam int FD_W   = LF_W + 1;
	localparam int NUM_W  = DIFF_W + FD_W;
	localparam int E_W    = NUM_W + 1;
	localparam int QW     = E_W - 16;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_SRCH  = 14'b00000000000010,
		S_CMP   = 14'b00000000000100,
		S_TAB   = 14'b00000000001000,
		S_MUL   = 14'b00000000010000,
		S_DIVGO = 14'b00000000100000,
		S_DIV   = 14'b00000001000000,
		S_EXPI  = 14'b00000010000000,
		S_EXP   = 14'b00000100000000,
		S_SC1   = 14'b00001000000000,
		S_SC2   = 14'b00010000000000,
		S_SC3   = 14'b00100000000000,
		S_FIN   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} bstate_t;

	logic [CDF_W-1:0] cdf_mem [TABLE_ENTRIES];
	logic [LC_W-1:0]  lc_mem  [TABLE_ENTRIES];
	logic [LF_W-1:0]  lf_mem  [TABLE_ENTRIES];

	bstate_t state_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [IW-1:0] mid_q;
	logic [3:0]    k_q;
	logic          out_valid_q;

	logic [X_W-1:0]          x_q;
	logic [CDF_W-1:0]        cdf_rd_q;
	logic signed [LC_W-1:0]  lc0_rd_q;
	logic signed [LC_W-1:0]  lc1_rd_q;
	logic [LF_W-1:0]         lf0_rd_q;
	logic [LF_W-1:0]         lf1_rd_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DIFF_W-1:0] den_q;
	logic signed [FD_W-1:0]  fd_q;
	logic [LF_W-1:0]         lf0_q;
	logic signed [NUM_W-1:0] prod_q;
	logic signed [E_W-1:0]   e_q;
	logic                    sat_hi_q;
	logic                    sat_lo_q;
	logic signed [6:0]       q_q;
	logic [15:0]             r_q;
	logic [31:0]             acc_q;
	logic [63:0]             plo_q;
	logic [51:0]             phi_q;
	logic [FREQ_W-1:0]       base_q;
	logic [FREQ_W-1:0]       fin_q;
	out_item_t               out_q;

	logic [IW:0]             mid_sum;
	logic [IW-1:0]           mid;
	logic [IW-1:0]           lo_p1;
	logic                    span_gt1;
	logic [IW-1:0]           wr_addr;
	logic                    take_cmd;
	logic                    out_free;
	logic                    lg_start;
	logic                    lg_busy;
	logic signed [LC_W-1:0]  lg;
	logic                    div_start;
	logic                    div_busy;
	logic signed [NUM_W-1:0] quo;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] den;
	logic signed [FD_W-1:0]  fd;
	logic signed [NUM_W-1:0] prod;
	logic signed [E_W-1:0]   lf0_ext;
	logic signed [QW-1:0]    q_full;
	logic [31:0]             root;
	logic [63:0]             acc_prod;
	logic [63:0]             plo_n;
	logic [51:0]             phi_n;
	logic [FREQ_W-1:0]       base_n;
	logic [55:0]             base_w;
	logic [5:0]              nsh;
	logic [55:0]             shifted;
	logic [FREQ_W-1:0]       fin;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IW:1];
	assign lo_p1     = lo_q + IW'(1);
	assign span_gt1  = (hi_q - lo_q) > IW'(1);
	assign wr_addr   = IW'(cmd.entry_index);
	assign cmd_ready = (state_q == S_IDLE);
	assign take_cmd  = cmd_valid && cmd_ready;
	assign lg_start  = take_cmd && cmd.is_sample;
	assign div_start = (state_q == S_DIVGO) && (den_q != '0);
	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	assign diff     = DIFF_W'(lg) - DIFF_W'(lc0_rd_q);
	assign den      = DIFF_W'(lc1_rd_q) - DIFF_W'(lc0_rd_q);
	assign fd       = signed'({1'b0, lf1_rd_q}) - signed'({1'b0, lf0_rd_q});
	assign prod     = diff_q * fd_q;
	assign lf0_ext  = E_W'(signed'({1'b0, lf0_q}));
	assign q_full   = e_q[E_W-1:16];
	assign root     = EXP2_ROOTS[k_q];
	assign acc_prod = 64'(acc_q) * 64'(root);
	assign plo_n    = 64'(HZ_PER_UNIT[31:0]) * 64'(acc_q);
	assign phi_n    = 52'(HZ_PER_UNIT[51:32]) * 52'(acc_q);
	assign base_n   = FREQ_W'({phi_q, 1'b0}) + FREQ_W'(plo_q[63:31]);
	assign base_w   = 56'(base_q);
	assign nsh      = 6'(-q_q);
	assign shifted  = q_q[6] ? (base_w >> nsh) : (base_w << q_q[1:0]);

	always_comb begin
		if (sat_hi_q)
			fin = FREQ_MAX;
		else if (sat_lo_q)
			fin = '0;
		else if (shifted > 56'(FREQ_MAX))
			fin = FREQ_MAX;
		else
			fin = shifted[FREQ_W-1:0];
	end

	lics_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lg_start),
		.x      (cmd.x),
		.busy   (lg_busy),
		.lg     (lg)
	);

	lics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (den_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	// Table memories: one write port, registered reads at the search point and bin edges.
	always_ff @(posedge clk) begin
		if (take_cmd && cmd.wr_en) begin
			cdf_mem[wr_addr] <= cmd.cdf_value;
			lc_mem[wr_addr]  <= cmd.log_cdf_value;
			lf_mem[wr_addr]  <= cmd.log_freq_value;
		end
		cdf_rd_q <= cdf_mem[mid];
		lc0_rd_q <= lc_mem[lo_q];
		lc1_rd_q <= lc_mem[lo_p1];
		lf0_rd_q <= lf_mem[lo_q];
		lf1_rd_q <= lf_mem[lo_p1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			k_q         <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take_cmd && cmd.is_sample) begin
						lo_q    <= '0;
						hi_q    <= IW'(TABLE_ENTRIES - 1);
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (span_gt1) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else begin
						state_q <= S_TAB;
					end
				end
				S_CMP: begin
					if ({1'b0, x_q} >= cdf_rd_q)
						lo_q <= mid_q;
					else
						hi_q <= mid_q;
					state_q <= S_SRCH;
				end
				S_TAB: begin
					if (!lg_busy)
						state_q <= S_MUL;
				end
				S_MUL:   state_q <= S_DIVGO;
				S_DIVGO: state_q <= (den_q == '0) ? S_EXPI : S_DIV;
				S_DIV: begin
					if (!div_busy)
						state_q <= S_EXPI;
				end
				S_EXPI: begin
					k_q     <= 4'd0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd15)
						state_q <= S_SC1;
				end
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_SC3;
				S_SC3: state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: x_q <= cmd.x;
			S_TAB: begin
				diff_q <= diff;
				den_q  <= den;
				fd_q   <= fd;
				lf0_q  <= lf0_rd_q;
			end
			S_MUL: prod_q <= prod;
			S_DIVGO: begin
				// A flat log bin takes the lower frequency as it stands.
				if (den_q == '0)
					e_q <= lf0_ext;
			end
			S_DIV: e_q <= lf0_ext + E_W'(quo);
			S_EXPI: begin
				sat_hi_q <= (q_full >= QW'(3));
				sat_lo_q <= (q_full < QW'(-63));
				q_q      <= 7'(q_full);
				r_q      <= e_q[15:0];
				acc_q    <= 32'h8000_0000;
			end
			S_EXP: begin
				if (r_q[4'd15 - k_q])
					acc_q <= acc_prod[62:31];
			end
			S_SC1: plo_q  <= plo_n;
			S_SC2: phi_q  <= phi_n;
			S_SC3: base_q <= base_n;
			S_FIN: fin_q  <= fin;
			S_OUT: begin
				if (out_free) begin
					out_q.frequency_hz <= fin_q;
					out_q.bin_index    <= BIN_W'(lo_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// File: src/log_interp_inverse_cdf_sampler.sv
// Top level of the log-interpolating inverse-CDF frequency sampler.
// A load request is taken while the back end is idle, leaves it free for the next request
// and writes one entry of the three tables when its index is in range. A sample request
// holds the back end from acceptance to result and needs no division when its bin is flat
// in the log domain: the binary search steps over the CDF memory, the log2 unit runs
// alongside it and usually sets the pace, then come the serial divider, the exp2 product
// chain and the scaling steps. Requests are queued two deep ahead of the back end and one
// result waits in the output register, so an output stall stops the input only once the
// back end and the queue are full as well. Table contents are undefined until written;
// there is no clearing pass after reset.
module log_interp_inverse_cdf_sampler #(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lics_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output lics_pkg::out_item_t result
);
	import lics_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	lics_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	lics_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: tb/log_interp_inverse_cdf_sampler_tb.sv
// Self-checking testbench of the log-interpolating inverse-CDF frequency sampler.
`timescale 1ns / 1ps

module log_interp_inverse_cdf_sampler_tb;
	import lics_pkg::*;

	localparam int ENTRIES = 128;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;

	log_interp_inverse_cdf_sampler #(.TABLE_ENTRIES(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #4 clk = ~clk;

	// Model copy of the three tables and the exp2 root constants.
	logic [CDF_W-1:0] cdf_mem [ENTRIES];
	logic signed [LC_W-1:0] log_cdf_mem [ENTRIES];
	logic [LF_W-1:0] log_freq_mem [ENTRIES];
	logic [63:0] root_q31 [16];

	in_item_t pending_requests [$];
	out_item_t expected_freqs [$];
	int errors = 0;
	int loads_seen = 0;
	int samples_seen = 0;
	int results_checked = 0;
	int drain_pause_at = 700;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit stall_mode = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v, res, b;
		v = v_in;
		res = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint log2_fixed(input logic [31:0] x);
		int p;
		logic [63:0] m;
		longint frac;
		p = 31;
		frac = 0;
		while (p > 0 && !x[p])
			p--;
		m = {32'b0, x} << (31 - p);
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(p - 32) * 65536 + frac;
	endfunction

	function automatic logic [FREQ_W-1:0] hz_from_log(input longint e);
		longint q, r;
		logic [63:0] acc, plo, phi, base;
		logic [15:0] rb;
		q = e / 65536;
		r = e - q * 65536;
		if (r < 0) begin
			r += 65536;
			q--;
		end
		if (q >= 3)
			return FREQ_MAX;
		if (q < -63)
			return '0;
		rb = r[15:0];
		acc = 64'd1 << 31;
		for (int k = 1; k <= 16; k++)
			if (rb[16-k])
				acc = (acc * root_q31[k-1]) >> 31;
		plo = (HZ_PER_UNIT & 64'hFFFF_FFFF) * acc;
		phi = (HZ_PER_UNIT >> 32) * acc;
		base = (phi << 1) + (plo >> 31);
		if (q >= 0)
			base = base << q;
		else
			base = base >> (-q);
		return (base > {10'b0, FREQ_MAX}) ? FREQ_MAX : base[FREQ_W-1:0];
	endfunction

	// Updates the table copy for a load, or appends the expected result of a sample.
	function automatic void predict_request(input in_item_t req);
		logic [32:0] x;
		int lo, hi, mid;
		longint lg, lc0, lc1, lf0, lf1, den, e;
		out_item_t res;
		if (req.kind == KIND_LOAD) begin
			cdf_mem[req.entry_index] = req.cdf_value;
			log_cdf_mem[req.entry_index] = req.log_cdf_value;
			log_freq_mem[req.entry_index] = req.log_freq_value;
			loads_seen++;
			return;
		end
		x = {1'b0, req.uniform_value};
		if (x == 0)
			x = 1;
		lo = 0;
		hi = ENTRIES - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (x >= cdf_mem[mid])
				lo = mid;
			else
				hi = mid;
		end
		lg = log2_fixed(x[31:0]);
		lc0 = longint'(log_cdf_mem[lo]);
		lc1 = longint'(log_cdf_mem[lo+1]);
		lf0 = longint'(log_freq_mem[lo]);
		lf1 = longint'(log_freq_mem[lo+1]);
		den = lc1 - lc0;
		if (den == 0)
			e = lf0;
		else
			e = lf0 + ((lg - lc0) * (lf1 - lf0)) / den;
		res.frequency_hz = hz_from_log(e);
		res.bin_index = lo[BIN_W-1:0];
		expected_freqs.push_back(res);
		samples_seen++;
	endfunction

	function automatic in_item_t load_req(input int idx, input logic [32:0] c,
			input logic signed [23:0] lc, input logic [17:0] lf);
		in_item_t r;
		r = '0;
		r.kind = KIND_LOAD;
		r.entry_index = idx[IDX_W-1:0];
		r.cdf_value = c;
		r.log_cdf_value = lc;
		r.log_freq_value = lf;
		r.uniform_value = $urandom();
		return r;
	endfunction

	function automatic in_item_t sample_req(input logic [31:0] x);
		in_item_t r;
		r = '0;
		r.kind = KIND_SAMPLE;
		r.entry_index = IDX_W'($urandom());
		r.cdf_value = {1'($urandom_range(0, 1)), 32'($urandom())};
		r.log_cdf_value = LC_W'($urandom());
		r.log_freq_value = LF_W'($urandom());
		r.uniform_value = x;
		return r;
	endfunction

	function automatic in_item_t random_load();
		logic [32:0] c;
		c = ($urandom_range(0, 9) == 0) ? 33'h1_0000_0000 : {1'b0, 32'($urandom())};
		return load_req($urandom_range(0, ENTRIES - 1), c,
			-24'($urandom_range(0, 8388608)), 18'($urandom_range(0, 131072)));
	endfunction

	// Driver: bursts of requests separated by random gaps, one drain pause.
	always @(posedge clk) begin
		if (push && !full) begin
			predict_request(item);
			idle_cycles = 0;
		end
		if (!(push && full)) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_requests.size() == 0 || !arst_n ||
					(loads_seen + samples_seen == drain_pause_at &&
					expected_freqs.size() != 0)) begin
				push <= 1'b0;
			end else begin
				if (loads_seen + samples_seen == drain_pause_at)
					drain_pause_at = -1;
				item <= pending_requests.pop_front();
				push <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Monitor: compares each popped result with the oldest expected one.
	always @(posedge clk) begin
		out_item_t want;
		if (pop && !empty) begin
			idle_cycles = 0;
			results_checked++;
			if (expected_freqs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result freq=%0d bin=%0d", $time,
					result.frequency_hz, result.bin_index);
			end else begin
				want = expected_freqs.pop_front();
				if (want.frequency_hz !== result.frequency_hz) begin
					errors++;
					$display("%0t: frequency_hz expected %0d actual %0d", $time,
						want.frequency_hz, result.frequency_hz);
				end
				if (want.bin_index !== result.bin_index) begin
					errors++;
					$display("%0t: bin_index expected %0d actual %0d", $time,
						want.bin_index, result.bin_index);
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = ($urandom_range(0, 2) == 0);
			stall_left = $urandom_range(5, 200);
		end else begin
			stall_left--;
		end
		pop <= stall_mode ? ($urandom_range(0, 9) < 3) : 1'b1;
	end

	always @(posedge clk) begin
		idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL log_interp_inverse_cdf_sampler");
			$finish;
		end
	end

	initial begin
		logic [63:0] rt;
		logic [32:0] c;
		rt = int_sqrt(64'd1 << 63);
		root_q31[0] = rt;
		for (int k = 1; k < 16; k++) begin
			rt = int_sqrt(rt << 31);
			root_q31[k] = rt;
		end

		// Fill every entry first so that no sample reads an unwritten one.
		for (int i = 0; i < ENTRIES; i++) begin
			c = (i == 0) ? 33'd1000 : (i == ENTRIES - 1) ? 33'h1_0000_0000 :
				33'((64'd1 << 32) * i / (ENTRIES - 1));
			pending_requests.push_back(load_req(i, c, -24'((ENTRIES - 1 - i) * 40000),
				18'(i * 1032)));
		end
		// The bin between entries 40 and 41 is flat in the log domain.
		pending_requests.push_back(load_req(41, 33'((64'd1 << 32) * 41 / 127),
			-24'(87 * 40000), 18'(41 * 1032)));
		pending_requests.push_back(sample_req(32'd0));
		pending_requests.push_back(sample_req(32'd1));
		pending_requests.push_back(sample_req(32'd999));
		pending_requests.push_back(sample_req(32'hFFFF_FFFF));
		pending_requests.push_back(sample_req(32'h8000_0000));
		pending_requests.push_back(sample_req(32'((64'd1 << 32) * 40 / 127 + 5)));
		pending_requests.push_back(sample_req(32'((64'd1 << 32) * 64 / 127)));
		pending_requests.push_back(sample_req(32'((64'd1 << 32) * 64 / 127 - 1)));
		// Steep top bin: a small log-CDF step against a large log-frequency step.
		pending_requests.push_back(load_req(126, 33'((64'd1 << 32) * 126 / 127),
			-24'd10, 18'd0));
		pending_requests.push_back(load_req(127, 33'd4000, 24'sd0, 18'd131072));
		pending_requests.push_back(sample_req(32'hFFFF_0000));
		pending_requests.push_back(sample_req(32'd5000));
		// Very negative exponent from a steep rising slope far from the entry.
		pending_requests.push_back(load_req(0, 33'h1_0000_0000, -24'd100, 18'd0));
		pending_requests.push_back(load_req(1, 33'h1_0000_0000, -24'd90, 18'd131072));
		pending_requests.push_back(sample_req(32'd1));
		pending_requests.push_back(sample_req(32'd7));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 4) == 0)
				pending_requests.push_back(random_load());
			else if ($urandom_range(0, 19) == 0)
				pending_requests.push_back(sample_req($urandom_range(0, 1) ? 32'd0 : '1));
			else
				pending_requests.push_back(sample_req($urandom()));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0);
		@(posedge clk);
		wait (!push);
		wait (expected_freqs.size() == 0);
		repeat (300) @(posedge clk);
		$display("Run covered %0d table loads and %0d samples, %0d results checked.",
			loads_seen, samples_seen, results_checked);
		if (errors == 0 && expected_freqs.size() == 0)
			$display("PASS log_interp_inverse_cdf_sampler");
		else
			$display("FAIL log_interp_inverse_cdf_sampler");
		$finish;
	end

endmodule
